@@ hw/rtl/lkv_pkg.sv @@
// Shared constants and types for the LRU key-value cache.
package lkv_pkg;

  localparam int unsigned EntriesDef = 16;
  localparam int unsigned KeyW       = 32;
  localparam int unsigned ValW       = 32;
  localparam int unsigned CapW       = 5;

  localparam logic [CapW-1:0] CapRst    = 5'd16;
  localparam logic [ValW-1:0] MissValue = '1;

  // command codes
  localparam logic CmdGet = 1'b0;
  localparam logic CmdPut = 1'b1;

  // operations on the valid/rank table
  typedef enum logic [1:0] {
    TblNone   = 2'd0,
    TblTouch  = 2'd1,
    TblInsert = 2'd2
  } table_op_e;

endpackage

@@ hw/rtl/lkv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lkv_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/lkv_table.sv @@
// Valid bits and recency ranks of all slots, with touch and insert updates.
module lkv_table #(
  parameter int unsigned Entries = lkv_pkg::EntriesDef,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lkv_pkg::table_op_e  op_i,
  input  logic [IdxW-1:0]     slot_i,
  input  logic [IdxW-1:0]     rank_i,
  input  logic [IdxW-1:0]     rd_idx_i,
  output logic                valid_o,
  output logic [IdxW-1:0]     rank_o
);

  logic [Entries-1:0] valid_q, valid_d;
  logic [IdxW-1:0]    rank_q [Entries];
  logic [IdxW-1:0]    rank_d [Entries];

  always_comb begin
    valid_d = valid_q;
    for (int unsigned i = 0; i < Entries; i++) begin
      rank_d[i] = rank_q[i];
    end
    case (op_i)
      lkv_pkg::TblTouch: begin
        // entries more recent than the touched one age by one
        for (int unsigned i = 0; i < Entries; i++) begin
          if (valid_q[i] && (rank_q[i] < rank_i)) begin
            rank_d[i] = rank_q[i] + IdxW'(1);
          end
        end
        rank_d[slot_i] = '0;
      end
      lkv_pkg::TblInsert: begin
        for (int unsigned i = 0; i < Entries; i++) begin
          if (valid_q[i]) begin
            rank_d[i] = rank_q[i] + IdxW'(1);
          end
        end
        rank_d[slot_i]  = '0;
        valid_d[slot_i] = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int unsigned i = 0; i < Entries; i++) begin
        rank_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      for (int unsigned i = 0; i < Entries; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  assign valid_o = valid_q[rd_idx_i];
  assign rank_o  = rank_q[rd_idx_i];

endmodule

@@ hw/rtl/lkv_scan.sv @@
// Per-slot compare unit: key match, least recent slot and first free slot.
module lkv_scan #(
  parameter int unsigned Entries = lkv_pkg::EntriesDef,
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      step_i,
  input  logic [IdxW-1:0]           idx_i,
  input  logic                      ent_valid_i,
  input  logic [IdxW-1:0]           ent_rank_i,
  input  logic [lkv_pkg::KeyW-1:0]  ent_key_i,
  input  logic [lkv_pkg::ValW-1:0]  ent_value_i,
  input  logic [lkv_pkg::KeyW-1:0]  key_i,
  output logic                      hit_o,
  output logic [IdxW-1:0]           hit_idx_o,
  output logic [IdxW-1:0]           hit_rank_o,
  output logic [lkv_pkg::ValW-1:0]  hit_value_o,
  output logic [IdxW-1:0]           lru_idx_o,
  output logic [IdxW-1:0]           free_idx_o
);

  logic                     hit_q, lru_seen_q, free_seen_q;
  logic [IdxW-1:0]          hit_idx_q, hit_rank_q, lru_idx_q, lru_rank_q, free_idx_q;
  logic [lkv_pkg::ValW-1:0] hit_value_q;
  logic                     match, lru_take, free_take;

  assign match     = step_i && ent_valid_i && (ent_key_i == key_i) && !hit_q;
  assign lru_take  = step_i && ent_valid_i && (!lru_seen_q || (ent_rank_i >= lru_rank_q));
  assign free_take = step_i && !ent_valid_i && !free_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q       <= 1'b0;
      lru_seen_q  <= 1'b0;
      free_seen_q <= 1'b0;
    end else if (clear_i) begin
      hit_q       <= 1'b0;
      lru_seen_q  <= 1'b0;
      free_seen_q <= 1'b0;
    end else begin
      if (match) begin
        hit_q <= 1'b1;
      end
      if (lru_take) begin
        lru_seen_q <= 1'b1;
      end
      if (free_take) begin
        free_seen_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (match) begin
      hit_idx_q   <= idx_i;
      hit_rank_q  <= ent_rank_i;
      hit_value_q <= ent_value_i;
    end
    if (lru_take) begin
      lru_idx_q  <= idx_i;
      lru_rank_q <= ent_rank_i;
    end
    if (free_take) begin
      free_idx_q <= idx_i;
    end
  end

  assign hit_o       = hit_q;
  assign hit_idx_o   = hit_idx_q;
  assign hit_rank_o  = hit_rank_q;
  assign hit_value_o = hit_value_q;
  assign lru_idx_o   = lru_idx_q;
  assign free_idx_o  = free_idx_q;

endmodule

@@ hw/rtl/lru_key_value_cache.sv @@
// LRU key-value cache: one request in flight, slots scanned one per cycle.
// done_o pulses once a taken request has passed the scan of every slot through the
// key/value RAM read port, then the update state and then the result register.
// A new request is taken only when idle; busy_o drops in the result cycle.
// done_o is high for one cycle only and the receiver cannot stall it; the result registers hold until the next update.
// Reset empties the cache and sets capacity to 16; no clearing pass is needed.
module lru_key_value_cache #(
  parameter int unsigned Entries = lkv_pkg::EntriesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  output logic                      busy_o,
  input  logic                      command_i,
  input  logic [lkv_pkg::KeyW-1:0]  key_i,
  input  logic signed [lkv_pkg::ValW-1:0] write_value_i,
  output logic                      done_o,
  output logic                      found_o,
  output logic signed [lkv_pkg::ValW-1:0] read_value_o,
  output logic                      evicted_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [lkv_pkg::CapW-1:0]  cfg_capacity_in_use_i
);

  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned CntW = $clog2(Entries + 1);
  localparam int unsigned CmpW = (CntW > lkv_pkg::CapW) ? CntW : lkv_pkg::CapW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StUpd  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [CntW-1:0] stp_q, stp_d;
  logic [IdxW-1:0] pidx_q;
  logic [CntW-1:0] used_q, used_d;
  logic [lkv_pkg::CapW-1:0] cap_q;
  logic cmd_q;
  logic [lkv_pkg::KeyW-1:0] key_q;
  logic [lkv_pkg::ValW-1:0] wval_q;
  logic done_q, found_q, evicted_q;
  logic [lkv_pkg::ValW-1:0] rval_q;

  logic accept, step, scan_clear;
  logic [IdxW-1:0] raddr;
  logic [lkv_pkg::KeyW-1:0] ram_key;
  logic [lkv_pkg::ValW-1:0] ram_val;
  logic ent_valid;
  logic [IdxW-1:0] ent_rank;
  logic hit;
  logic [IdxW-1:0] hit_idx, hit_rank, lru_idx, free_idx;
  logic [lkv_pkg::ValW-1:0] hit_value;

  logic [lkv_pkg::CapW-1:0] cap_adj;
  logic full, upd;
  lkv_pkg::table_op_e tbl_op;
  logic [IdxW-1:0] tbl_slot;
  logic key_we, val_we;
  logic [IdxW-1:0] wr_slot;

  assign accept      = start_i && (state_q == StIdle);
  assign busy_o      = (state_q != StIdle);
  // capacity changes only between requests, never alongside a new one
  assign cfg_ready_o = (state_q == StIdle) && !start_i;
  assign raddr       = stp_q[IdxW-1:0];
  assign step        = (state_q == StScan) && (stp_q != '0);
  assign scan_clear  = accept;
  assign upd         = (state_q == StUpd);

  // capacity zero acts as one; above Entries it is bounded by a full table
  assign cap_adj = (cap_q == '0) ? lkv_pkg::CapW'(1) : cap_q;
  assign full    = (CmpW'(used_q) >= CmpW'(cap_adj)) || (used_q == CntW'(Entries));

  always_comb begin
    state_d = state_q;
    stp_d   = stp_q;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StScan;
          stp_d   = '0;
        end
      end
      StScan: begin
        stp_d = stp_q + CntW'(1);
        if (stp_q == CntW'(Entries)) begin
          state_d = StUpd;
        end
      end
      StUpd: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    tbl_op   = lkv_pkg::TblNone;
    tbl_slot = hit_idx;
    key_we   = 1'b0;
    val_we   = 1'b0;
    wr_slot  = hit_idx;
    used_d   = used_q;
    if (upd) begin
      if (hit) begin
        tbl_op = lkv_pkg::TblTouch;
        val_we = (cmd_q == lkv_pkg::CmdPut);
      end else if (cmd_q == lkv_pkg::CmdPut) begin
        tbl_op   = lkv_pkg::TblInsert;
        tbl_slot = full ? lru_idx : free_idx;
        wr_slot  = tbl_slot;
        key_we   = 1'b1;
        val_we   = 1'b1;
        if (!full) begin
          used_d = used_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      stp_q   <= '0;
      used_q  <= '0;
      cap_q   <= lkv_pkg::CapRst;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      stp_q   <= stp_d;
      used_q  <= used_d;
      done_q  <= upd;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_capacity_in_use_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= raddr;
    if (accept) begin
      cmd_q  <= command_i;
      key_q  <= key_i;
      wval_q <= write_value_i;
    end
    if (upd) begin
      found_q   <= hit;
      rval_q    <= (hit && (cmd_q == lkv_pkg::CmdGet)) ? hit_value : lkv_pkg::MissValue;
      evicted_q <= !hit && (cmd_q == lkv_pkg::CmdPut) && full;
    end
  end

  lkv_ram #(
    .Width (lkv_pkg::KeyW),
    .Depth (Entries)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (wr_slot),
    .wdata_i (key_q),
    .raddr_i (raddr),
    .rdata_o (ram_key)
  );

  lkv_ram #(
    .Width (lkv_pkg::ValW),
    .Depth (Entries)
  ) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (wr_slot),
    .wdata_i (wval_q),
    .raddr_i (raddr),
    .rdata_o (ram_val)
  );

  lkv_table #(
    .Entries (Entries)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (tbl_op),
    .slot_i   (tbl_slot),
    .rank_i   (hit_rank),
    .rd_idx_i (pidx_q),
    .valid_o  (ent_valid),
    .rank_o   (ent_rank)
  );

  lkv_scan #(
    .Entries (Entries)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (scan_clear),
    .step_i      (step),
    .idx_i       (pidx_q),
    .ent_valid_i (ent_valid),
    .ent_rank_i  (ent_rank),
    .ent_key_i   (ram_key),
    .ent_value_i (ram_val),
    .key_i       (key_q),
    .hit_o       (hit),
    .hit_idx_o   (hit_idx),
    .hit_rank_o  (hit_rank),
    .hit_value_o (hit_value),
    .lru_idx_o   (lru_idx),
    .free_idx_o  (free_idx)
  );

  assign done_o       = done_q;
  assign found_o      = found_q;
  assign read_value_o = rval_q;
  assign evicted_o    = evicted_q;

endmodule
